@@ rtl/qrmp_pkg.sv @@
`timescale 1ns / 1ps
package qrmp_pkg;
	localparam int MAX_VERSION_DEF = 40;

	typedef enum logic [1:0] {
		ACT_RESTART = 2'd0,
		ACT_PLACE   = 2'd1,
		ACT_PROBE   = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT,
		ST_PROBE,
		ST_PEMIT
	} state_t;

	typedef struct packed {
		logic fn;
		logic dk;
		logic rs;
	} layer_t;

	// alignment centers per version: count, then up to seven centers
	function automatic logic [63:0] align_row(input logic [5:0] v);
		logic [63:0] t;
		case (v)
			6'd1:  t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd2:  t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd18, 8'd6, 8'd2};
			6'd3:  t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd22, 8'd6, 8'd2};
			6'd4:  t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd26, 8'd6, 8'd2};
			6'd5:  t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd30, 8'd6, 8'd2};
			6'd6:  t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd34, 8'd6, 8'd2};
			6'd7:  t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd38, 8'd22, 8'd6, 8'd3};
			6'd8:  t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd42, 8'd24, 8'd6, 8'd3};
			6'd9:  t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd46, 8'd26, 8'd6, 8'd3};
			6'd10: t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd50, 8'd28, 8'd6, 8'd3};
			6'd11: t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd54, 8'd30, 8'd6, 8'd3};
			6'd12: t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd58, 8'd32, 8'd6, 8'd3};
			6'd13: t = {8'd0, 8'd0, 8'd0, 8'd0, 8'd62, 8'd34, 8'd6, 8'd3};
			6'd14: t = {8'd0, 8'd0, 8'd0, 8'd66, 8'd46, 8'd26, 8'd6, 8'd4};
			6'd15: t = {8'd0, 8'd0, 8'd0, 8'd70, 8'd48, 8'd26, 8'd6, 8'd4};
			6'd16: t = {8'd0, 8'd0, 8'd0, 8'd74, 8'd50, 8'd26, 8'd6, 8'd4};
			6'd17: t = {8'd0, 8'd0, 8'd0, 8'd78, 8'd54, 8'd30, 8'd6, 8'd4};
			6'd18: t = {8'd0, 8'd0, 8'd0, 8'd82, 8'd56, 8'd30, 8'd6, 8'd4};
			6'd19: t = {8'd0, 8'd0, 8'd0, 8'd86, 8'd58, 8'd30, 8'd6, 8'd4};
			6'd20: t = {8'd0, 8'd0, 8'd0, 8'd90, 8'd62, 8'd34, 8'd6, 8'd4};
			6'd21: t = {8'd0, 8'd0, 8'd94, 8'd72, 8'd50, 8'd28, 8'd6, 8'd5};
			6'd22: t = {8'd0, 8'd0, 8'd98, 8'd74, 8'd50, 8'd26, 8'd6, 8'd5};
			6'd23: t = {8'd0, 8'd0, 8'd102, 8'd78, 8'd54, 8'd30, 8'd6, 8'd5};
			6'd24: t = {8'd0, 8'd0, 8'd106, 8'd80, 8'd54, 8'd28, 8'd6, 8'd5};
			6'd25: t = {8'd0, 8'd0, 8'd110, 8'd84, 8'd58, 8'd32, 8'd6, 8'd5};
			6'd26: t = {8'd0, 8'd0, 8'd114, 8'd86, 8'd58, 8'd30, 8'd6, 8'd5};
			6'd27: t = {8'd0, 8'd0, 8'd118, 8'd90, 8'd62, 8'd34, 8'd6, 8'd5};
			6'd28: t = {8'd0, 8'd122, 8'd98, 8'd74, 8'd50, 8'd26, 8'd6, 8'd6};
			6'd29: t = {8'd0, 8'd126, 8'd102, 8'd78, 8'd54, 8'd30, 8'd6, 8'd6};
			6'd30: t = {8'd0, 8'd130, 8'd104, 8'd78, 8'd52, 8'd26, 8'd6, 8'd6};
			6'd31: t = {8'd0, 8'd134, 8'd108, 8'd82, 8'd56, 8'd30, 8'd6, 8'd6};
			6'd32: t = {8'd0, 8'd138, 8'd112, 8'd86, 8'd60, 8'd34, 8'd6, 8'd6};
			6'd33: t = {8'd0, 8'd142, 8'd114, 8'd86, 8'd58, 8'd30, 8'd6, 8'd6};
			6'd34: t = {8'd0, 8'd146, 8'd118, 8'd90, 8'd62, 8'd34, 8'd6, 8'd6};
			6'd35: t = {8'd150, 8'd126, 8'd102, 8'd78, 8'd54, 8'd30, 8'd6, 8'd7};
			6'd36: t = {8'd154, 8'd128, 8'd102, 8'd76, 8'd50, 8'd24, 8'd6, 8'd7};
			6'd37: t = {8'd158, 8'd132, 8'd106, 8'd80, 8'd54, 8'd28, 8'd6, 8'd7};
			6'd38: t = {8'd162, 8'd136, 8'd110, 8'd84, 8'd58, 8'd32, 8'd6, 8'd7};
			6'd39: t = {8'd166, 8'd138, 8'd110, 8'd82, 8'd54, 8'd26, 8'd6, 8'd7};
			6'd40: t = {8'd170, 8'd142, 8'd114, 8'd86, 8'd58, 8'd30, 8'd6, 8'd7};
			default: t = '0;
		endcase
		return t;
	endfunction
endpackage

@@ rtl/qr_module_placement_core.sv @@
`timescale 1ns / 1ps
// Place byte: after the accept, each bit walks the zigzag in SEARCH, visiting free
// and skipped positions, and is then offered in EMIT; the walk takes longer where
// function modules are skipped, and m_tready held low stalls the result.
// Probe: accept, a classify state (PROBE), then the result transfer (PEMIT). Restart: handled at the accept.
// One item at a time; s_tready is low while an item is at work.
// arst_n clears the walk to the version-1 start and symbol_version to 1.
module qr_module_placement_core #(
	parameter int MAX_VERSION = qrmp_pkg::MAX_VERSION_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // action[1:0], data_byte[9:2], probe_row[17:10], probe_col[25:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // row[7:0], col[15:8], dark[16], is_function[17], reserved_area[18], matrix_full[19]
	output logic        m_tlast
);
	localparam logic [5:0] VMAX = 6'(MAX_VERSION);

	qrmp_pkg::state_t st_q, st_d;
	logic [5:0] ver_q, ev;
	logic [7:0] sc_q, wr_q;
	logic mu_q, po_q, wf_q;
	logic [6:0] sd_q;
	logic [7:0] byte_q;
	logic [2:0] k_q;
	logic [7:0] lr, lc;
	logic [8:0] size;
	qrmp_pkg::layer_t lay;
	logic [7:0] orow_q, ocol_q;
	logic odk_q, ofn_q, ors_q, ofull_q, olast_q;

	assign ev   = (ver_q == 6'd0) ? 6'd1 : ((ver_q > VMAX) ? VMAX : ver_q);
	assign size = 9'd17 + {ev, 2'b00};

	// shared classifier: walk position during search, probe coordinate else
	always_comb begin
		if (st_q == qrmp_pkg::ST_SEARCH) begin
			lr = wr_q;
			lc = sc_q - {7'd0, po_q};
		end else begin
			lr = byte_q;
			lc = orow_q;
		end
	end

	qrmp_layer u_layer (.ver(ev), .r(lr), .c(lc), .lay(lay));

	logic s_acc;
	assign s_tready = (st_q == qrmp_pkg::ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (st_q == qrmp_pkg::ST_EMIT) || (st_q == qrmp_pkg::ST_PEMIT);
	assign m_tdata  = {4'd0, ofull_q, ors_q, ofn_q, odk_q, ocol_q, orow_q};
	assign m_tlast  = olast_q;

	logic fin_now, free_hit, endstrip;
	assign fin_now  = {1'b0, sd_q} >= size[8:1];
	assign free_hit = ({1'b0, lr} < size) && ({1'b0, lc} < size) && !lay.fn;
	assign endstrip = po_q && (mu_q ? (wr_q == 8'd0) : ({1'b0, wr_q} >= size - 9'd1));

	always_comb begin
		st_d = st_q;
		case (st_q)
			qrmp_pkg::ST_IDLE: begin
				if (s_acc) begin
					case (qrmp_pkg::action_t'(s_tdata[1:0]))
						qrmp_pkg::ACT_PLACE: st_d = qrmp_pkg::ST_SEARCH;
						qrmp_pkg::ACT_PROBE: st_d = qrmp_pkg::ST_PROBE;
						default:             st_d = qrmp_pkg::ST_IDLE;
					endcase
				end
			end
			qrmp_pkg::ST_SEARCH: begin
				if (wf_q || fin_now || free_hit) st_d = qrmp_pkg::ST_EMIT;
			end
			qrmp_pkg::ST_EMIT: begin
				if (m_tready) st_d = (k_q == 3'd7) ? qrmp_pkg::ST_IDLE : qrmp_pkg::ST_SEARCH;
			end
			qrmp_pkg::ST_PROBE: st_d = qrmp_pkg::ST_PEMIT;
			qrmp_pkg::ST_PEMIT: if (m_tready) st_d = qrmp_pkg::ST_IDLE;
			default: st_d = qrmp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= qrmp_pkg::ST_IDLE;
			ver_q <= 6'd1;
			sc_q  <= 8'd20;
			wr_q  <= 8'd20;
			mu_q  <= 1'b1;
			po_q  <= 1'b0;
			sd_q  <= '0;
			wf_q  <= 1'b0;
			k_q   <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) ver_q <= cfg_wdata;
			case (st_q)
				qrmp_pkg::ST_IDLE: begin
					k_q <= '0;
					if (s_acc && qrmp_pkg::action_t'(s_tdata[1:0]) == qrmp_pkg::ACT_RESTART) begin
						sc_q <= size[7:0] - 8'd1;
						wr_q <= size[7:0] - 8'd1;
						mu_q <= 1'b1;
						po_q <= 1'b0;
						sd_q <= '0;
						wf_q <= 1'b0;
					end
				end
				qrmp_pkg::ST_SEARCH: begin
					if (!wf_q && fin_now) begin
						wf_q <= 1'b1;
					end else if (!wf_q) begin
						// advance one position
						po_q <= !po_q;
						if (po_q && !endstrip) wr_q <= mu_q ? wr_q - 8'd1 : wr_q + 8'd1;
						if (endstrip) begin
							sd_q <= sd_q + 7'd1;
							sc_q <= sc_q - ((sc_q == 8'd8) ? 8'd3 : 8'd2);
							mu_q <= !mu_q;
							if ({1'b0, sd_q + 7'd1} >= size[8:1]) wf_q <= 1'b1;
						end
					end
				end
				qrmp_pkg::ST_EMIT: if (m_tready) k_q <= k_q + 3'd1;
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			if (qrmp_pkg::action_t'(s_tdata[1:0]) == qrmp_pkg::ACT_PLACE) begin
				byte_q <= s_tdata[9:2];
			end else begin
				byte_q <= s_tdata[17:10];
				orow_q <= s_tdata[25:18];
			end
		end
		if (st_q == qrmp_pkg::ST_SEARCH) begin
			if (!wf_q && !fin_now && free_hit) begin
				orow_q  <= lr;
				ocol_q  <= lc;
				odk_q   <= byte_q[3'd7 - k_q];
				ofull_q <= 1'b0;
			end else begin
				orow_q  <= '0;
				ocol_q  <= '0;
				odk_q   <= 1'b0;
				ofull_q <= 1'b1;
			end
			ofn_q   <= 1'b0;
			ors_q   <= 1'b0;
			olast_q <= (k_q == 3'd7);
		end
		if (st_q == qrmp_pkg::ST_PROBE) begin
			ocol_q  <= orow_q;
			orow_q  <= byte_q;
			odk_q   <= lay.dk;
			ofn_q   <= lay.fn;
			ors_q   <= lay.rs;
			ofull_q <= wf_q;
			olast_q <= 1'b1;
		end
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("ready while result pending");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == qrmp_pkg::ST_EMIT && ofull_q) |-> m_tdata[15:0] == 16'd0)
		else $error("dropped bit with coordinate");
endmodule

@@ rtl/qrmp_layer.sv @@
`timescale 1ns / 1ps
// Function layer classifier for one module coordinate.
module qrmp_layer (
	input  logic [5:0] ver,
	input  logic [7:0] r,
	input  logic [7:0] c,
	output qrmp_pkg::layer_t lay
);
	logic [8:0] size;
	logic [63:0] tab;
	logic [2:0] n;
	logic [6:0] near_r, dark_r;
	logic [6:0] near_c, dark_c;
	logic al_hit, al_dk;
	logic [8:0] r9, c9;

	assign size = 9'd17 + {ver, 2'b00};
	assign tab  = qrmp_pkg::align_row(ver);
	assign n    = tab[2:0];
	assign r9   = {1'b0, r};
	assign c9   = {1'b0, c};

	// per center: within 2, and exactly at distance 1
	always_comb begin
		for (int i = 0; i < 7; i++) begin
			logic [8:0] cv, dr, dc;
			cv = {1'b0, tab[8*(i+1) +: 8]};
			dr = (r9 > cv) ? r9 - cv : cv - r9;
			dc = (c9 > cv) ? c9 - cv : cv - c9;
			near_r[i] = dr <= 9'd2;
			dark_r[i] = dr == 9'd1;
			near_c[i] = dc <= 9'd2;
			dark_c[i] = dc == 9'd1;
		end
	end

	// pair (i,j) allowed unless it is a finder corner; first match in scan order wins
	always_comb begin
		logic done;
		al_hit = 1'b0;
		al_dk  = 1'b0;
		done   = 1'b0;
		for (int i = 1; i <= 7; i++) begin
			for (int j = 1; j <= 7; j++) begin
				if (!done && i <= n && j <= n &&
				    ((1 < i && i < n) || (1 < j && j < n) || (i == n && j == n)) &&
				    near_r[i-1] && near_c[j-1]) begin
					done   = 1'b1;
					al_hit = 1'b1;
					// chebyshev distance 1: max(dr,dc)==1
					al_dk  = !((dark_r[i-1] && !dark_c[j-1] && c9 != {1'b0, tab[8*j +: 8]} + 9'd2
					           && {1'b0, tab[8*j +: 8]} != c9 + 9'd2) ||
					          (dark_c[j-1] && !dark_r[i-1] && r9 != {1'b0, tab[8*i +: 8]} + 9'd2
					           && {1'b0, tab[8*i +: 8]} != r9 + 9'd2) ||
					          (dark_r[i-1] && dark_c[j-1]));
				end
			end
		end
	end

	function automatic logic fdk(input logic [8:0] a, input logic [8:0] b,
	                              input logic [8:0] ca, input logic [8:0] cb);
		logic [8:0] da, db, m;
		da = (a > ca) ? a - ca : ca - a;
		db = (b > cb) ? b - cb : cb - b;
		m  = (da > db) ? da : db;
		return m != 9'd2;
	endfunction

	always_comb begin
		lay = '0;
		if (r9 >= size || c9 >= size) begin
			lay = '0;
		end else if (r9 == size - 9'd8 && c9 == 9'd8) begin
			lay = '{fn: 1'b1, dk: 1'b1, rs: 1'b0};
		end else if (al_hit) begin
			lay = '{fn: 1'b1, dk: al_dk, rs: 1'b0};
		end else if (r9 == 9'd6 && c9 >= 9'd8 && c9 < size - 9'd8) begin
			lay = '{fn: 1'b1, dk: !c[0], rs: 1'b0};
		end else if (c9 == 9'd6 && r9 >= 9'd8 && r9 < size - 9'd8) begin
			lay = '{fn: 1'b1, dk: !r[0], rs: 1'b0};
		end else if ((c9 == 9'd7 && r9 <= 9'd6) || (r9 == 9'd7 && c9 <= 9'd7) ||
		             (c9 == size - 9'd8 && r9 <= 9'd6) || (r9 == 9'd7 && c9 >= size - 9'd8) ||
		             (r9 == size - 9'd8 && c9 <= 9'd7) || (c9 == 9'd7 && r9 >= size - 9'd7)) begin
			lay = '{fn: 1'b1, dk: 1'b0, rs: 1'b0};
		end else if (r9 < 9'd7 && c9 < 9'd7) begin
			lay = '{fn: 1'b1, dk: fdk(r9, c9, 9'd3, 9'd3), rs: 1'b0};
		end else if (r9 < 9'd7 && c9 >= size - 9'd7) begin
			lay = '{fn: 1'b1, dk: fdk(r9, c9, 9'd3, size - 9'd4), rs: 1'b0};
		end else if (r9 >= size - 9'd7 && c9 < 9'd7) begin
			lay = '{fn: 1'b1, dk: fdk(r9, c9, size - 9'd4, 9'd3), rs: 1'b0};
		end else if (ver >= 6'd7 &&
		             ((r9 <= 9'd5 && c9 >= size - 9'd11 && c9 <= size - 9'd9) ||
		              (r9 >= size - 9'd11 && r9 <= size - 9'd9 && c9 <= 9'd5))) begin
			lay = '{fn: 1'b1, dk: 1'b0, rs: 1'b1};
		end else if ((c9 == 9'd8 && r9 <= 9'd8) || (r9 == 9'd8 && c9 <= 9'd8) ||
		             (r9 == 9'd8 && c9 >= size - 9'd8) || (c9 == 9'd8 && r9 >= size - 9'd8)) begin
			lay = '{fn: 1'b1, dk: 1'b0, rs: 1'b1};
		end
	end
endmodule

@@ bench/qr_module_placement_checker.sv @@
`timescale 1ns / 1ps
module qr_module_placement_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        m_tlast,
	output int          errors,
	output int          pending
);
	typedef struct {
		logic [7:0] row;
		logic [7:0] col;
		logic       dark;
		logic       fn;
		logic       rs;
		logic       full;
		logic       last;
	} module_result_t;

	// alignment centers: count then centers, per version
	localparam int ALIGN_CENTERS [0:39][0:7] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0},       '{2, 6, 18, 0, 0, 0, 0, 0},
		'{2, 6, 22, 0, 0, 0, 0, 0},      '{2, 6, 26, 0, 0, 0, 0, 0},
		'{2, 6, 30, 0, 0, 0, 0, 0},      '{2, 6, 34, 0, 0, 0, 0, 0},
		'{3, 6, 22, 38, 0, 0, 0, 0},     '{3, 6, 24, 42, 0, 0, 0, 0},
		'{3, 6, 26, 46, 0, 0, 0, 0},     '{3, 6, 28, 50, 0, 0, 0, 0},
		'{3, 6, 30, 54, 0, 0, 0, 0},     '{3, 6, 32, 58, 0, 0, 0, 0},
		'{3, 6, 34, 62, 0, 0, 0, 0},     '{4, 6, 26, 46, 66, 0, 0, 0},
		'{4, 6, 26, 48, 70, 0, 0, 0},    '{4, 6, 26, 50, 74, 0, 0, 0},
		'{4, 6, 30, 54, 78, 0, 0, 0},    '{4, 6, 30, 56, 82, 0, 0, 0},
		'{4, 6, 30, 58, 86, 0, 0, 0},    '{4, 6, 34, 62, 90, 0, 0, 0},
		'{5, 6, 28, 50, 72, 94, 0, 0},   '{5, 6, 26, 50, 74, 98, 0, 0},
		'{5, 6, 30, 54, 78, 102, 0, 0},  '{5, 6, 28, 54, 80, 106, 0, 0},
		'{5, 6, 32, 58, 84, 110, 0, 0},  '{5, 6, 30, 58, 86, 114, 0, 0},
		'{5, 6, 34, 62, 90, 118, 0, 0},  '{6, 6, 26, 50, 74, 98, 122, 0},
		'{6, 6, 30, 54, 78, 102, 126, 0}, '{6, 6, 26, 52, 78, 104, 130, 0},
		'{6, 6, 30, 56, 82, 108, 134, 0}, '{6, 6, 34, 60, 86, 112, 138, 0},
		'{6, 6, 30, 58, 86, 114, 142, 0}, '{6, 6, 34, 62, 90, 118, 146, 0},
		'{7, 6, 30, 54, 78, 102, 126, 150}, '{7, 6, 24, 50, 76, 102, 128, 154},
		'{7, 6, 28, 54, 80, 106, 132, 158}, '{7, 6, 32, 58, 84, 110, 136, 162},
		'{7, 6, 26, 54, 82, 110, 138, 166}, '{7, 6, 30, 58, 86, 114, 142, 170}
	};

	logic [5:0]     version_reg;
	int unsigned    strip_col, walk_row, strips, walk_done;
	bit             going_up, pair_ofs;
	module_result_t expected_results[$];

	function automatic int unsigned active_version();
		int unsigned v;
		v = {26'd0, version_reg};
		if (v < 1) v = 1;
		if (v > qrmp_pkg::MAX_VERSION_DEF) v = qrmp_pkg::MAX_VERSION_DEF;
		return v;
	endfunction

	function automatic int chebyshev(int r, int c, int cr, int cc);
		int dr, dc;
		dr = (r > cr) ? r - cr : cr - r;
		dc = (c > cc) ? c - cc : cc - c;
		return (dr > dc) ? dr : dc;
	endfunction

	// function layer at (r, c): {fn, dk, rs}; the first matching pattern wins
	function automatic logic [2:0] function_layer(int v, int r, int c);
		int sz, n, d;
		sz = 17 + 4 * v;
		if (r >= sz || c >= sz) return 3'b000;
		if (r == sz - 8 && c == 8) return 3'b110;
		n = ALIGN_CENTERS[v-1][0];
		for (int i = 1; i <= n; i++)
			for (int j = 1; j <= n; j++)
				if ((1 < i && i < n) || (1 < j && j < n) || (i == n && j == n)) begin
					d = chebyshev(r, c, ALIGN_CENTERS[v-1][i], ALIGN_CENTERS[v-1][j]);
					if (d <= 2) return {1'b1, d != 1, 1'b0};
				end
		if (r == 6 && c >= 8 && c < sz - 8) return {1'b1, c[0] == 1'b0, 1'b0};
		if (c == 6 && r >= 8 && r < sz - 8) return {1'b1, r[0] == 1'b0, 1'b0};
		if ((c == 7 && r <= 6) || (r == 7 && c <= 7) || (c == sz - 8 && r <= 6) ||
		    (r == 7 && c >= sz - 8) || (r == sz - 8 && c <= 7) || (c == 7 && r >= sz - 7))
			return 3'b100;
		if (r < 7 && c < 7) return {1'b1, chebyshev(r, c, 3, 3) != 2, 1'b0};
		if (r < 7 && c >= sz - 7) return {1'b1, chebyshev(r, c, 3, sz - 4) != 2, 1'b0};
		if (r >= sz - 7 && c < 7) return {1'b1, chebyshev(r, c, sz - 4, 3) != 2, 1'b0};
		if (v >= 7 && ((r <= 5 && c >= sz - 11 && c <= sz - 9) ||
		               (r >= sz - 11 && r <= sz - 9 && c <= 5)))
			return 3'b101;
		if ((c == 8 && r <= 8) || (r == 8 && c <= 8) || (r == 8 && c >= sz - 8) ||
		    (c == 8 && r >= sz - 8))
			return 3'b101;
		return 3'b000;
	endfunction

	task automatic restart_walk();
		int unsigned sz;
		sz = 17 + 4 * active_version();
		strip_col = sz - 1;
		walk_row  = sz - 1;
		going_up  = 1'b1;
		pair_ofs  = 1'b0;
		strips    = 0;
		walk_done = 0;
	endtask

	task automatic step_walk(int unsigned sz);
		bit at_end;
		at_end = 1'b0;
		if (!pair_ofs) begin
			pair_ofs = 1'b1;
			return;
		end
		pair_ofs = 1'b0;
		if (going_up) begin
			if (walk_row == 0) at_end = 1'b1; else walk_row--;
		end else begin
			if (walk_row >= sz - 1) at_end = 1'b1; else walk_row++;
		end
		if (at_end) begin
			strips    = (strips + 1) & 127;
			strip_col = (strip_col - ((strip_col == 8) ? 3 : 2)) & 8'hFF;
			going_up  = !going_up;
			if (strips >= sz / 2) walk_done = 1;
		end
	endtask

	// next free data module along the zigzag; 0 when the walk is exhausted
	task automatic find_free(int v, output bit found, output int unsigned r, output int unsigned c);
		int unsigned sz;
		logic [2:0]  lay;
		sz = 17 + 4 * v;
		found = 1'b0;
		r = 0;
		c = 0;
		while (!walk_done) begin
			if (strips >= sz / 2) begin
				walk_done = 1;
				break;
			end
			r = walk_row & 8'hFF;
			c = (strip_col - pair_ofs) & 8'hFF;
			lay = function_layer(v, r, c);
			step_walk(sz);
			if (r < sz && c < sz && !lay[2]) begin
				found = 1'b1;
				break;
			end
		end
		if (!found) begin
			r = 0;
			c = 0;
		end
	endtask

	task automatic predict_item(logic [31:0] item);
		qrmp_pkg::action_t act;
		module_result_t    res;
		bit                found;
		int unsigned       r, c;
		logic [2:0]        lay;
		int                v;
		act = qrmp_pkg::action_t'(item[1:0]);
		v   = active_version();
		case (act)
			qrmp_pkg::ACT_RESTART: restart_walk();
			qrmp_pkg::ACT_PLACE: begin
				for (int k = 0; k < 8; k++) begin
					find_free(v, found, r, c);
					res.row  = r[7:0];
					res.col  = c[7:0];
					res.dark = found ? item[2 + 7 - k] : 1'b0;
					res.fn   = 1'b0;
					res.rs   = 1'b0;
					res.full = !found;
					res.last = (k == 7);
					expected_results.push_back(res);
				end
			end
			qrmp_pkg::ACT_PROBE: begin
				lay = function_layer(v, int'(item[17:10]), int'(item[25:18]));
				res.row  = item[17:10];
				res.col  = item[25:18];
				res.dark = lay[1];
				res.fn   = lay[2];
				res.rs   = lay[0];
				res.full = walk_done[0];
				res.last = 1'b1;
				expected_results.push_back(res);
			end
			default: ;
		endcase
	endtask

	task automatic check_result();
		module_result_t e;
		if (expected_results.size() == 0) begin
			$error("unexpected result transfer: tdata %h", m_tdata);
			errors++;
			return;
		end
		e = expected_results.pop_front();
		if (m_tdata[7:0] !== e.row) begin
			$error("row: expected %0d actual %0d", e.row, m_tdata[7:0]); errors++;
		end
		if (m_tdata[15:8] !== e.col) begin
			$error("col: expected %0d actual %0d", e.col, m_tdata[15:8]); errors++;
		end
		if (m_tdata[16] !== e.dark) begin
			$error("dark: expected %0b actual %0b", e.dark, m_tdata[16]); errors++;
		end
		if (m_tdata[17] !== e.fn) begin
			$error("is_function: expected %0b actual %0b", e.fn, m_tdata[17]); errors++;
		end
		if (m_tdata[18] !== e.rs) begin
			$error("reserved_area: expected %0b actual %0b", e.rs, m_tdata[18]); errors++;
		end
		if (m_tdata[19] !== e.full) begin
			$error("matrix_full: expected %0b actual %0b", e.full, m_tdata[19]); errors++;
		end
		if (m_tlast !== e.last) begin
			$error("last: expected %0b actual %0b", e.last, m_tlast); errors++;
		end
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_reg = 6'd1;
			restart_walk();
			expected_results.delete();
		end else begin
			if (m_tvalid && m_tready) check_result();
			if (s_tvalid && s_tready) predict_item(s_tdata);
			if (cfg_we) version_reg = cfg_wdata;
		end
		pending = expected_results.size();
	end
endmodule

@@ bench/qr_module_placement_core_tb.sv @@
`timescale 1ns / 1ps
module qr_module_placement_core_tb;
	// cycles without any transfer before the run is declared hung; a search
	// across a shrunken symbol after a version change can be slow
	localparam int STALL_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [5:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // action[1:0], data_byte[9:2], probe_row[17:10], probe_col[25:18]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // row[7:0], col[15:8], dark[16], is_function[17], reserved_area[18], matrix_full[19]
	logic        m_tlast;

	int errors, pending;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;          // random gaps on both sides when set
	bit result_taken = 1'b0;
	int sink_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	qr_module_placement_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	qr_module_placement_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.errors(errors), .pending(pending)
	);

	// watchdog on transfer activity
	always @(posedge clk) begin
		result_taken = m_tvalid && m_tready;
		if ((s_tvalid && s_tready) || result_taken) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL qr_module_placement_core");
			$finish;
		end
	end

	// result side: random hold-off drawn per transfer
	always @(negedge clk) begin
		if (result_taken) sink_hold = idle_on ? $urandom_range(0, 3) : 0;
		if (sink_hold > 0) begin
			m_tready = 1'b0;
			sink_hold--;
		end else begin
			m_tready = arst_n;
		end
	end

	// one input transfer; called and returning at a falling edge
	task automatic send_item(qrmp_pkg::action_t act, logic [7:0] data, logic [7:0] prow,
	                         logic [7:0] pcol);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata  = {6'd0, pcol, prow, data, act};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_probe(int r, int c);
		send_item(qrmp_pkg::ACT_PROBE, 8'($urandom_range(0, 255)), 8'(r), 8'(c));
	endtask

	// block must be idle: nothing in flight, then a short settle
	task automatic write_version(logic [5:0] v);
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wdata = v;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// mostly placements so the walk gets deep, plus probes and noise
	task automatic random_item(int size, int place_pct);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < place_pct)
			send_item(qrmp_pkg::ACT_PLACE, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		else if (pick < place_pct + (100 - place_pct) * 3 / 4) begin
			if ($urandom_range(0, 3) == 0) send_probe($urandom_range(0, 255), $urandom_range(0, 255));
			else send_probe($urandom_range(0, size - 1), $urandom_range(0, size - 1));
		end else if ($urandom_range(0, 1) == 0)
			send_item(qrmp_pkg::ACT_NONE, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		else
			send_item(qrmp_pkg::ACT_RESTART, 8'd0, 8'd0, 8'd0);
	endtask

	int phase_version [10] = '{1, 1, 40, 7, 0, 63, 2, 14, 1, 3};
	bit phase_restart [10] = '{1, 0, 0, 1, 1, 1, 0, 1, 1, 1};
	int phase_place   [10] = '{90, 95, 60, 70, 85, 70, 80, 70, 95, 75};

	initial begin
		int eff, sz;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: version 1 straight out of reset
		send_item(qrmp_pkg::ACT_PLACE, 8'h00, 8'h00, 8'h00);
		send_item(qrmp_pkg::ACT_PLACE, 8'hFF, 8'hFF, 8'hFF);
		send_item(qrmp_pkg::ACT_PLACE, 8'hA5, 8'h00, 8'h00);
		send_probe(0, 0);     // finder corner
		send_probe(3, 3);     // finder center
		send_probe(7, 7);     // separator
		send_probe(13, 8);    // dark module
		send_probe(6, 10);    // timing row
		send_probe(10, 6);    // timing column
		send_probe(8, 0);     // format reserve
		send_probe(20, 20);   // plain data module
		send_probe(21, 0);    // just outside the symbol
		send_probe(255, 255);
		send_item(qrmp_pkg::ACT_NONE, 8'hFF, 8'hFF, 8'hFF);
		send_item(qrmp_pkg::ACT_RESTART, 8'h00, 8'h00, 8'h00);
		send_item(qrmp_pkg::ACT_PLACE, 8'h3C, 8'h00, 8'h00);

		// directed: version 7 adds version reserve and a full alignment grid
		write_version(6'd7);
		send_item(qrmp_pkg::ACT_RESTART, 8'h00, 8'h00, 8'h00);
		send_probe(0, 34);    // version reserve, top right
		send_probe(34, 5);    // version reserve, bottom left
		send_probe(22, 22);   // alignment center
		send_probe(22, 23);   // alignment ring
		send_probe(6, 22);    // alignment over timing
		send_item(qrmp_pkg::ACT_PLACE, 8'h81, 8'h00, 8'h00);

		// random phases over several versions; some keep the old walk running
		for (int p = 0; p < 10; p++) begin
			write_version(6'(phase_version[p]));
			idle_on = (p % 4) != 2;
			eff = phase_version[p] < 1 ? 1 : (phase_version[p] > 40 ? 40 : phase_version[p]);
			sz  = 17 + 4 * eff;
			if (phase_restart[p]) send_item(qrmp_pkg::ACT_RESTART, 8'h00, 8'h00, 8'h00);
			repeat (28) random_item(sz, phase_place[p]);
		end

		s_tvalid = 1'b0;
		idle_on  = 1'b1;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS qr_module_placement_core");
		else
			$display("FAIL qr_module_placement_core");
		$finish;
	end
endmodule
